/* rtl/plic_pkg.sv */
package plic_pkg;

  localparam int NUM_SOURCES  = 32;
  localparam int NUM_CONTEXTS = 2;

  localparam int SRC_W  = $clog2(NUM_SOURCES);
  localparam int CTX_W  = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int DATA_W = 32;
  localparam int OFF_W  = 26;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;

  localparam logic [OFF_W-1:0] PRIO_END      = 26'h000_1000;
  localparam logic [OFF_W-1:0] PENDING_OFF   = 26'h000_1000;
  localparam logic [OFF_W-1:0] ENABLE_BASE   = 26'h000_2000;
  localparam logic [OFF_W-1:0] ENABLE_STRIDE = 26'h000_0080;
  localparam logic [OFF_W-1:0] CTX_BASE      = 26'h020_0000;
  localparam logic [OFF_W-1:0] CTX_STRIDE    = 26'h000_1000;
  localparam logic [OFF_W-1:0] ENABLE_SPAN   = OFF_W'(NUM_CONTEXTS * 128);
  localparam logic [OFF_W-1:0] CTX_SPAN      = OFF_W'(NUM_CONTEXTS * 4096);

  localparam logic [11:0] REG_THRESHOLD = 12'h000;
  localparam logic [11:0] REG_CLAIM     = 12'h004;

  localparam logic [DATA_W-1:0] SRC_MASK =
    DATA_W'((64'd1 << NUM_SOURCES) - 64'd1) & 32'hFFFF_FFFE;

  typedef struct packed {
    logic             clear;
    logic             valid;
    logic             elig;
    logic [SRC_W-1:0] src;
  } scan_beat_t;

endpackage

/* rtl/plic_scan.sv */
module plic_scan (
  input  logic                         clk,
  input  plic_pkg::scan_beat_t         beat,
  input  logic [plic_pkg::DATA_W-1:0]  prio,
  input  logic [plic_pkg::DATA_W-1:0]  threshold,
  output logic [plic_pkg::SRC_W-1:0]   best_src
);

  logic [plic_pkg::DATA_W-1:0] lead_prio;

  always_ff @(posedge clk) begin
    if (beat.clear) begin
      best_src  <= '0;
      lead_prio <= '0;
    end else if (beat.valid && beat.elig && (prio > threshold) && (prio > lead_prio)) begin
      best_src  <= beat.src;
      lead_prio <= prio;
    end
  end

endmodule

/* rtl/platform_interrupt_controller.sv */
// Channel  | Handshake     | Fields
// ---------+---------------+-----------------------------------------------
// access   | start / busy  | mode, offset, write_data, source_lines
// result   | done (strobe) | read_data, machine_irq, supervisor_irq
//
// Each scan walks the priority memory one source per cycle through one compare
// unit; a claim read runs three scans, every other beat two. A priority read
// also passes through S_PRIO_WAIT. Synchronous active-high reset clears the
// control state, the context registers and the priority valid bits. The
// receiver cannot stall: done lasts exactly one cycle.
module platform_interrupt_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         mode,
  input  logic [plic_pkg::OFF_W-1:0]         offset,
  input  logic [plic_pkg::DATA_W-1:0]        write_data,
  input  logic [plic_pkg::DATA_W-1:0]        source_lines,
  output logic                               done,
  output logic [plic_pkg::DATA_W-1:0]        read_data,
  output logic                               machine_irq,
  output logic                               supervisor_irq
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ACCESS    = 3'd1;
  localparam logic [2:0] S_PRIO_WAIT = 3'd2;
  localparam logic [2:0] S_SCAN      = 3'd3;
  localparam logic [2:0] S_FLUSH     = 3'd4;
  localparam logic [2:0] S_EVAL      = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  localparam logic [1:0] PH_CLAIM = 2'd0;
  localparam logic [1:0] PH_IRQ0  = 2'd1;
  localparam logic [1:0] PH_IRQ1  = 2'd2;

  localparam int SW = plic_pkg::SRC_W;
  localparam int CW = plic_pkg::CTX_W;
  localparam int DW = plic_pkg::DATA_W;
  localparam int NS = plic_pkg::NUM_SOURCES;
  localparam int NC = plic_pkg::NUM_CONTEXTS;

  logic [2:0]    state;
  logic [1:0]    phase;
  logic [CW-1:0] scan_ctx;
  logic [SW-1:0] cnt;

  logic [1:0]                 mode_q;
  logic [plic_pkg::OFF_W-1:0] off_q;
  logic [DW-1:0]              wdata_q;
  logic [DW-1:0]              lines_q;

  logic [DW-1:0] enable    [NC];
  logic [DW-1:0] threshold [NC];
  logic [SW-1:0] claimed   [NC];

  logic [DW-1:0] prio_mem [NS];
  logic [NS-1:0] prio_vld;
  logic [DW-1:0] prio_raw;
  logic          prio_raw_vld;
  logic [DW-1:0] prio_q;
  logic [SW-1:0] rd_addr;

  logic                 beat_valid;
  logic [SW-1:0]        beat_src;
  plic_pkg::scan_beat_t beat;
  logic [SW-1:0]        best_src;

  logic                       rd, wr;
  logic                       prio_hit, pend_hit, en_hit, cx_hit;
  logic [SW-1:0]              prio_idx;
  logic                       prio_we;
  logic [plic_pkg::OFF_W-1:0] en_rel, cx_rel;
  logic [CW-1:0]              en_ctx, cx_ctx;
  logic [11:0]                cx_reg;
  logic                       claim_rd;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  assign rd = (state == S_ACCESS) && (mode_q == plic_pkg::MODE_READ);
  assign wr = (state == S_ACCESS) && (mode_q == plic_pkg::MODE_WRITE);

  assign prio_hit = (off_q < plic_pkg::PRIO_END) && (off_q[11:2] < 10'(NS));
  assign prio_idx = off_q[2 +: SW];
  assign prio_we  = wr && prio_hit && (prio_idx != '0);
  assign pend_hit = (off_q == plic_pkg::PENDING_OFF);

  assign en_rel = off_q - plic_pkg::ENABLE_BASE;
  assign en_hit = (off_q >= plic_pkg::ENABLE_BASE) && (en_rel < plic_pkg::ENABLE_SPAN)
                  && (en_rel[6:0] == 7'd0);
  assign en_ctx = en_rel[7 +: CW];

  assign cx_rel = off_q - plic_pkg::CTX_BASE;
  assign cx_hit = (off_q >= plic_pkg::CTX_BASE) && (cx_rel < plic_pkg::CTX_SPAN);
  assign cx_reg = cx_rel[11:0];
  assign cx_ctx = cx_rel[12 +: CW];
  assign claim_rd = rd && cx_hit && (cx_reg == plic_pkg::REG_CLAIM);

  assign rd_addr = (state == S_ACCESS) ? prio_idx : cnt;

  always_ff @(posedge clk) begin
    if (prio_we) begin
      prio_mem[prio_idx] <= wdata_q;
    end
    prio_raw <= prio_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prio_vld     <= '0;
      prio_raw_vld <= 1'b0;
    end else begin
      prio_raw_vld <= prio_vld[rd_addr];
      if (prio_we) begin
        prio_vld[prio_idx] <= 1'b1;
      end
    end
  end

  assign prio_q = prio_raw_vld ? prio_raw : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else begin
      beat_valid <= (state == S_SCAN);
    end
    beat_src <= cnt;
  end

  assign beat.clear = (state == S_SCAN) && (cnt == SW'(1));
  assign beat.valid = beat_valid;
  assign beat.src   = beat_src;
  assign beat.elig  = lines_q[beat_src] && enable[scan_ctx][beat_src]
                      && (beat_src != claimed[scan_ctx]);

  plic_scan u_scan (
    .clk       (clk),
    .beat      (beat),
    .prio      (prio_q),
    .threshold (threshold[scan_ctx]),
    .best_src  (best_src)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_IRQ0;
      scan_ctx <= '0;
      cnt      <= '0;
      for (int c = 0; c < NC; c++) begin
        enable[c]    <= '0;
        threshold[c] <= '0;
        claimed[c]   <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          if (wr && en_hit) begin
            enable[en_ctx] <= wdata_q;
          end
          if (wr && cx_hit && (cx_reg == plic_pkg::REG_THRESHOLD)) begin
            threshold[cx_ctx] <= wdata_q;
          end
          if (wr && cx_hit && (cx_reg == plic_pkg::REG_CLAIM)
              && (wdata_q == DW'(claimed[cx_ctx]))) begin
            claimed[cx_ctx] <= '0;
          end
          if (claim_rd) begin
            phase    <= PH_CLAIM;
            scan_ctx <= cx_ctx;
          end else begin
            phase    <= PH_IRQ0;
            scan_ctx <= '0;
          end
          cnt <= SW'(1);
          if (rd && prio_hit) begin
            state <= S_PRIO_WAIT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_PRIO_WAIT: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          cnt <= cnt + SW'(1);
          if (cnt == SW'(NS - 1)) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          cnt <= SW'(1);
          case (phase)
            PH_CLAIM: begin
              if (best_src != '0) begin
                claimed[scan_ctx] <= best_src;
              end
              phase    <= PH_IRQ0;
              scan_ctx <= '0;
              state    <= S_SCAN;
            end
            PH_IRQ0: begin
              if (NC > 1) begin
                phase    <= PH_IRQ1;
                scan_ctx <= CW'(NC - 1);
                state    <= S_SCAN;
              end else begin
                state <= S_DONE;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      mode_q         <= mode;
      off_q          <= {offset[plic_pkg::OFF_W-1:2], 2'b00};
      wdata_q        <= write_data;
      lines_q        <= source_lines & plic_pkg::SRC_MASK;
      read_data      <= '0;
      machine_irq    <= 1'b0;
      supervisor_irq <= 1'b0;
    end else if (state == S_ACCESS) begin
      if (rd && pend_hit) begin
        read_data <= lines_q;
      end
      if (rd && en_hit) begin
        read_data <= enable[en_ctx];
      end
      if (rd && cx_hit && (cx_reg == plic_pkg::REG_THRESHOLD)) begin
        read_data <= threshold[cx_ctx];
      end
    end else if (state == S_PRIO_WAIT) begin
      read_data <= prio_q;
    end else if (state == S_EVAL) begin
      case (phase)
        PH_CLAIM: read_data      <= DW'(best_src);
        PH_IRQ0:  machine_irq    <= (best_src != '0);
        default:  supervisor_irq <= (best_src != '0);
      endcase
    end
  end

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plic_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;
  localparam int         BEATS     = 1950;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              machine_irq;
    logic              supervisor_irq;
  } irq_response_t;

  class irq_scoreboard;
    logic [DATA_W-1:0] prio      [NUM_SOURCES];
    logic [DATA_W-1:0] enable    [NUM_CONTEXTS];
    logic [DATA_W-1:0] threshold [NUM_CONTEXTS];
    logic [SRC_W-1:0]  claimed   [NUM_CONTEXTS];
    irq_response_t     expected_responses[$];
    int                faults;

    function new();
      foreach (prio[s]) prio[s] = '0;
      foreach (enable[c]) begin
        enable[c]    = '0;
        threshold[c] = '0;
        claimed[c]   = '0;
      end
      faults = 0;
    endfunction

    function logic [SRC_W-1:0] best_pending(logic [DATA_W-1:0] lines, int ctx);
      logic [DATA_W-1:0] top_prio;
      logic [SRC_W-1:0]  winner;
      top_prio = '0;
      winner   = '0;
      for (int s = 1; s < NUM_SOURCES; s++) begin
        if (lines[s] && enable[ctx][s] && s != claimed[ctx] &&
            prio[s] > threshold[ctx] && prio[s] > top_prio) begin
          winner   = SRC_W'(s);
          top_prio = prio[s];
        end
      end
      return winner;
    endfunction

    function void note_access(logic [1:0] acc_mode, logic [OFF_W-1:0] acc_off,
                              logic [DATA_W-1:0] wdata, logic [DATA_W-1:0] raw_lines);
      logic [OFF_W-1:0]  addr;
      logic [OFF_W-1:0]  rel;
      logic [DATA_W-1:0] lines;
      logic [SRC_W-1:0]  src;
      irq_response_t     resp;
      int                ctx;
      bit                wr;
      addr           = {acc_off[OFF_W-1:2], 2'b00};
      lines          = raw_lines & SRC_MASK;
      wr             = (acc_mode == MODE_WRITE);
      resp.read_data = '0;
      if (acc_mode == MODE_READ || acc_mode == MODE_WRITE) begin
        if (addr < PRIO_END) begin
          if (addr[11:2] < NUM_SOURCES) begin
            if (!wr) resp.read_data = prio[addr[2 +: SRC_W]];
            else if (addr[11:2] != 0) prio[addr[2 +: SRC_W]] = wdata;
          end
        end else if (addr == PENDING_OFF) begin
          if (!wr) resp.read_data = lines;
        end else if (addr >= ENABLE_BASE && addr < ENABLE_BASE + ENABLE_SPAN) begin
          rel = addr - ENABLE_BASE;
          if (rel % ENABLE_STRIDE == 0) begin
            ctx = int'(rel / ENABLE_STRIDE);
            if (!wr) resp.read_data = enable[ctx];
            else enable[ctx] = wdata;
          end
        end else if (addr >= CTX_BASE && addr < CTX_BASE + CTX_SPAN) begin
          rel = addr - CTX_BASE;
          ctx = int'(rel / CTX_STRIDE);
          if (rel[11:0] == REG_THRESHOLD) begin
            if (!wr) resp.read_data = threshold[ctx];
            else threshold[ctx] = wdata;
          end else if (rel[11:0] == REG_CLAIM) begin
            if (!wr) begin
              src = best_pending(lines, ctx);
              if (src != 0) claimed[ctx] = src;
              resp.read_data = DATA_W'(src);
            end else if (wdata == DATA_W'(claimed[ctx])) begin
              claimed[ctx] = '0;
            end
          end
        end
      end
      resp.machine_irq    = best_pending(lines, 0) != 0;
      resp.supervisor_irq = NUM_CONTEXTS > 1 && best_pending(lines, NUM_CONTEXTS - 1) != 0;
      expected_responses.push_back(resp);
    endfunction

    function void check_response(logic [DATA_W-1:0] rdata, logic mirq, logic sirq);
      irq_response_t exp_r;
      if (expected_responses.size() == 0) begin
        $error("response with no access outstanding: read_data %h", rdata);
        faults++;
        return;
      end
      exp_r = expected_responses.pop_front();
      if (rdata !== exp_r.read_data) begin
        $error("read_data: expected %h, got %h", exp_r.read_data, rdata);
        faults++;
      end
      if (mirq !== exp_r.machine_irq) begin
        $error("machine_irq: expected %b, got %b", exp_r.machine_irq, mirq);
        faults++;
      end
      if (sirq !== exp_r.supervisor_irq) begin
        $error("supervisor_irq: expected %b, got %b", exp_r.supervisor_irq, sirq);
        faults++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        mode;
  logic [OFF_W-1:0]  offset;
  logic [DATA_W-1:0] write_data;
  logic [DATA_W-1:0] source_lines;
  logic              done;
  logic [DATA_W-1:0] read_data;
  logic              machine_irq;
  logic              supervisor_irq;

  irq_scoreboard sb;
  bit            idle_on;

  platform_interrupt_controller dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .offset         (offset),
    .write_data     (write_data),
    .source_lines   (source_lines),
    .done           (done),
    .read_data      (read_data),
    .machine_irq    (machine_irq),
    .supervisor_irq (supervisor_irq)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_response(read_data, machine_irq, supervisor_irq);
  end

  function automatic logic [OFF_W-1:0] low_bits();
    return OFF_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [OFF_W-1:0] prio_off(int s);
    return OFF_W'(4 * s) | low_bits();
  endfunction

  function automatic logic [OFF_W-1:0] enable_off(int c);
    return ENABLE_BASE + OFF_W'(c) * ENABLE_STRIDE + low_bits();
  endfunction

  function automatic logic [OFF_W-1:0] thresh_off(int c);
    return CTX_BASE + OFF_W'(c) * CTX_STRIDE + OFF_W'(REG_THRESHOLD) + low_bits();
  endfunction

  function automatic logic [OFF_W-1:0] claim_off(int c);
    return CTX_BASE + OFF_W'(c) * CTX_STRIDE + OFF_W'(REG_CLAIM) + low_bits();
  endfunction

  function automatic logic [OFF_W-1:0] stray_off();
    case ($urandom_range(0, 5))
      0: return OFF_W'(4 * $urandom_range(NUM_SOURCES, 1023)) | low_bits();
      1: return PENDING_OFF + OFF_W'(4 * $urandom_range(1, 1023)) | low_bits();
      2: return ENABLE_BASE + OFF_W'(4 * $urandom_range(1, 31))
                + OFF_W'($urandom_range(0, NUM_CONTEXTS - 1)) * ENABLE_STRIDE + low_bits();
      3: return OFF_W'($urandom_range(ENABLE_BASE + ENABLE_SPAN, CTX_BASE - 1));
      4: return CTX_BASE + OFF_W'($urandom_range(0, NUM_CONTEXTS - 1)) * CTX_STRIDE
                + OFF_W'(4 * $urandom_range(2, 1023)) + low_bits();
      default: return OFF_W'($urandom_range(CTX_BASE + CTX_SPAN, 26'h3FF_FFFF));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_lines();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return '1;
      default: return DATA_W'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic drive_beat(input logic [1:0] m, input logic [OFF_W-1:0] o,
                            input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] l);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    mode         <= m;
    offset       <= o;
    write_data   <= w;
    source_lines <= l;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_access(m, o, w, l);
  endtask

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int               iter;
    int               beats;
    int               c;
    int               pick;
    logic [DATA_W-1:0] id;
    sb           = new();
    rst          = 1'b1;
    start        = 1'b0;
    mode         = MODE_NONE;
    offset       = '0;
    write_data   = '0;
    source_lines = '0;
    idle_on      = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    drive_beat(MODE_READ,  PENDING_OFF, '0, '1);
    drive_beat(MODE_WRITE, prio_off(0), '1, '0);
    drive_beat(MODE_READ,  prio_off(0), '0, '0);
    drive_beat(MODE_WRITE, prio_off(NUM_SOURCES - 1), '1, '0);
    drive_beat(MODE_READ,  prio_off(NUM_SOURCES - 1), '0, '0);
    drive_beat(MODE_WRITE, prio_off(1), 32'd1, '0);
    drive_beat(MODE_WRITE, prio_off(2), 32'd1, '0);
    drive_beat(MODE_WRITE, enable_off(0), '1, '0);
    drive_beat(MODE_WRITE, enable_off(1), 32'h0000_0006, '1);
    drive_beat(MODE_READ,  enable_off(1), '0, '1);
    drive_beat(MODE_READ,  claim_off(0), '0, 32'h0000_0006);
    drive_beat(MODE_READ,  claim_off(0), '0, 32'h0000_0006);
    drive_beat(MODE_WRITE, claim_off(0), 32'd1, 32'h0000_0006);
    drive_beat(MODE_WRITE, claim_off(0), 32'd2, 32'h0000_0006);
    drive_beat(MODE_READ,  claim_off(0), '0, '0);
    drive_beat(MODE_READ,  claim_off(0), '0, '1);
    drive_beat(MODE_WRITE, thresh_off(1), '1, '1);
    drive_beat(MODE_READ,  thresh_off(1), '0, '1);
    drive_beat(MODE_READ,  claim_off(1), '0, '1);
    drive_beat(MODE_WRITE, thresh_off(1), '0, '1);
    drive_beat(MODE_BAD,   PENDING_OFF, '1, '1);
    drive_beat(MODE_NONE,  claim_off(0), '0, '1);
    drive_beat(MODE_WRITE, PENDING_OFF, '1, '1);
    drive_beat(MODE_READ,  prio_off(NUM_SOURCES), '0, '1);
    drive_beat(MODE_READ,  26'h3FF_FFFF, '0, '1);

    iter  = 0;
    beats = 0;
    while (beats < BEATS) begin
      if (iter % 64 == 0) idle_on = $urandom_range(0, 2) != 0;
      iter++;
      c    = $urandom_range(0, NUM_CONTEXTS - 1);
      pick = $urandom_range(0, 99);
      beats++;
      if (pick < 15) begin
        drive_beat(MODE_WRITE, prio_off($urandom_range(0, NUM_SOURCES - 1)),
                   rand_level(), rand_lines());
      end else if (pick < 20) begin
        drive_beat(MODE_READ, prio_off($urandom_range(0, NUM_SOURCES - 1)), $urandom,
                   rand_lines());
      end else if (pick < 27) begin
        drive_beat(MODE_WRITE, enable_off(c), ($urandom_range(0, 3) == 0) ? '1 : $urandom,
                   rand_lines());
      end else if (pick < 29) begin
        drive_beat(MODE_READ, enable_off(c), $urandom, rand_lines());
      end else if (pick < 34) begin
        drive_beat(MODE_WRITE, thresh_off(c),
                   ($urandom_range(0, 5) == 0) ? rand_level() : DATA_W'($urandom_range(0, 3)),
                   rand_lines());
      end else if (pick < 36) begin
        drive_beat(MODE_READ, thresh_off(c), $urandom, rand_lines());
      end else if (pick < 61) begin
        drive_beat(MODE_READ, claim_off(c), $urandom, rand_lines());
      end else if (pick < 79) begin
        case ($urandom_range(0, 6))
          0:       id = DATA_W'($urandom_range(0, NUM_SOURCES - 1));
          1:       id = $urandom;
          default: id = DATA_W'(sb.claimed[c]);
        endcase
        drive_beat(MODE_WRITE, claim_off(c), id, rand_lines());
      end else if (pick < 85) begin
        drive_beat(MODE_READ, PENDING_OFF | low_bits(), $urandom, rand_lines());
      end else begin
        if (pick < 90)
          drive_beat(($urandom_range(0, 1) != 0) ? MODE_NONE : MODE_BAD, OFF_W'($urandom),
                     $urandom, rand_lines());
        else if (pick < 95)
          drive_beat(2'($urandom_range(0, 1)), stray_off(), $urandom, rand_lines());
        else
          drive_beat(2'($urandom_range(0, 3)), OFF_W'($urandom), $urandom, rand_lines());
      end
    end
    start <= 1'b0;

    while (sb.expected_responses.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.expected_responses.size() != 0) begin
      $error("%0d responses never arrived", sb.expected_responses.size());
      sb.faults++;
    end
    if (sb.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/plic_pkg.sv
rtl/plic_scan.sv
rtl/platform_interrupt_controller.sv
test/tb_top.sv
